@@ hdl/field_rate_format_detector_top_macros.svh @@
// assertion macros shared by the checker
`ifndef FIELD_RATE_FORMAT_DETECTOR_TOP_MACROS_SVH
`define FIELD_RATE_FORMAT_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define FRFD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define FRFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/frfd_pkg.sv @@
`timescale 1ns / 1ps

package frfd_pkg;

	// parameter defaults
	localparam int RING_MAX_DEF   = 16;
	localparam int TIME_WIDTH_DEF = 32;

	// field widths
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int TPS_W     = 32;
	localparam int RS_W      = 5;
	localparam int THR_W     = 6;
	localparam int FMT_W     = 8;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 6;
	localparam int FT_W      = 16;
	localparam int QUO_W     = 17;
	localparam int DEN_W     = TPS_W + CNT_W;
	// numerator below 2^55 whenever a division runs
	localparam int NUM_W_MIN = 56;

	// band limits of the ten-field time in ms
	localparam logic [FT_W-1:0] FT_SAT      = 16'hFFFF;
	localparam logic [FT_W-1:0] BAND50_LO   = 16'd195;
	localparam logic [FT_W-1:0] BAND50_HI   = 16'd205;
	localparam logic [FT_W-1:0] BAND60A_LO  = 16'd160;
	localparam logic [FT_W-1:0] BAND60A_HI  = 16'd172;
	localparam logic [FT_W-1:0] BAND60B_LO  = 16'd330;
	localparam logic [FT_W-1:0] BAND60B_HI  = 16'd340;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_DETECT    = 3'd0,
		REG_CHANGE_THRESHOLD = 3'd1,
		REG_TICKS_PER_SECOND = 3'd2,
		REG_RING_SIZE        = 3'd3,
		REG_FORMAT_50        = 3'd4,
		REG_FORMAT_60        = 3'd5
	} cfg_reg_t;

	// picture kinds
	typedef enum logic [1:0] {
		KIND_ODD  = 2'd0,
		KIND_EVEN = 2'd1,
		KIND_PROG = 2'd2
	} kind_t;

	// rate classes
	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_50HZ  = 2'd1,
		CLS_60HZ  = 2'd2,
		CLS_UNEXP = 2'd3
	} rate_class_t;

	typedef struct packed {
		logic             enable_detect;
		logic [THR_W-1:0] change_threshold;
		logic [TPS_W-1:0] ticks_per_second;
		logic [RS_W-1:0]  ring_size;
		logic [FMT_W-1:0] format_50;
		logic [FMT_W-1:0] format_60;
	} cfg_t;

	typedef struct packed {
		logic             measurement_done;
		logic [FT_W-1:0]  field_time_x10;
		logic [1:0]       rate_class;
		logic             switch_request;
		logic [FMT_W-1:0] switch_format;
	} res_t;

	typedef struct packed {
		logic sub;
	} alu_op_t;

endpackage

@@ hdl/frfd_field_if.sv @@
`timescale 1ns / 1ps

interface frfd_field_if #(
	parameter int TIME_WIDTH = frfd_pkg::TIME_WIDTH_DEF
);
	logic                       valid;
	logic                       ready;
	logic [TIME_WIDTH-1:0]      timestamp;
	logic                       running_late;
	logic [1:0]                 picture_kind;
	logic [frfd_pkg::IDX_W-1:0] frame_index;
	logic                       source_is_50hz;

	modport source (
		output valid, timestamp, running_late, picture_kind, frame_index, source_is_50hz,
		input  ready
	);
	modport sink (
		input  valid, timestamp, running_late, picture_kind, frame_index, source_is_50hz,
		output ready
	);
endinterface

@@ hdl/frfd_result_if.sv @@
`timescale 1ns / 1ps

interface frfd_result_if;
	logic                       valid;
	logic                       ready;
	logic                       measurement_done;
	logic [frfd_pkg::FT_W-1:0]  field_time_x10;
	logic [1:0]                 rate_class;
	logic                       switch_request;
	logic [frfd_pkg::FMT_W-1:0] switch_format;

	modport source (
		output valid, measurement_done, field_time_x10, rate_class, switch_request,
			switch_format,
		input  ready
	);
	modport sink (
		input  valid, measurement_done, field_time_x10, rate_class, switch_request,
			switch_format,
		output ready
	);
endinterface

@@ hdl/frfd_alu.sv @@
`timescale 1ns / 1ps

module frfd_alu #(
	parameter int W = frfd_pkg::NUM_W_MIN
) (
	input  frfd_pkg::alu_op_t op,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic [W-1:0]      sum,
	output logic              borrow
);

	logic [W:0] res;

	// shared add / subtract, top bit is carry or borrow
	always_comb begin
		if (op.sub) begin
			res = {1'b0, a} - {1'b0, b};
		end else begin
			res = {1'b0, a} + {1'b0, b};
		end
	end

	assign sum    = res[W-1:0];
	assign borrow = res[W];

endmodule

@@ hdl/frfd_core.sv @@
`timescale 1ns / 1ps

module frfd_core #(
	parameter int RING_MAX   = frfd_pkg::RING_MAX_DEF,
	parameter int TIME_WIDTH = frfd_pkg::TIME_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frfd_pkg::cfg_t             cfg,
	input  logic                       start,
	input  logic [TIME_WIDTH-1:0]      timestamp,
	input  logic                       running_late,
	input  logic [1:0]                 picture_kind,
	input  logic [frfd_pkg::IDX_W-1:0] frame_index,
	input  logic                       source_is_50hz,
	output logic                       idle,
	output logic                       emit,
	input  logic                       out_free,
	output frfd_pkg::res_t             res
);

	localparam int DW        = (TIME_WIDTH > frfd_pkg::NUM_W_MIN) ? TIME_WIDTH
		: frfd_pkg::NUM_W_MIN;
	localparam int RS_W      = frfd_pkg::RS_W;
	localparam int CNT_W     = frfd_pkg::CNT_W;
	localparam int QUO_W     = frfd_pkg::QUO_W;
	localparam int DEN_W     = frfd_pkg::DEN_W;
	localparam int FT_W      = frfd_pkg::FT_W;
	localparam int STEP_W    = $clog2(QUO_W);
	localparam int NUM_TERMS = 5;
	localparam int RING_CAP  = (RING_MAX > 31) ? 31 : RING_MAX;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_ELAP = 10'b00_0000_0010,
		ST_MUL  = 10'b00_0000_0100,
		ST_SEV  = 10'b00_0000_1000,
		ST_CMP  = 10'b00_0001_0000,
		ST_NUM  = 10'b00_0010_0000,
		ST_RND  = 10'b00_0100_0000,
		ST_DIV  = 10'b00_1000_0000,
		ST_CLS  = 10'b01_0000_0000,
		ST_FIN  = 10'b10_0000_0000
	} state_t;

	// x mod m for x below 32, m at least 2
	function automatic logic [RS_W-1:0] mod_small(input logic [RS_W-1:0] x,
		input logic [RS_W-1:0] m);
		logic [RS_W+3:0] r;
		logic [RS_W+3:0] d;
		r = {4'b0, x};
		for (int k = 3; k >= 0; k--) begin
			d = {4'b0, m} << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[RS_W-1:0];
	endfunction

	// shifts whose weights add up to 10000
	function automatic int num_shift(input logic [2:0] k);
		int s;
		case (k)
			3'd0:    s = 13;
			3'd1:    s = 10;
			3'd2:    s = 9;
			3'd3:    s = 8;
			default: s = 4;
		endcase
		return s;
	endfunction

	state_t                     state_q;
	logic [STEP_W-1:0]          step_q;
	logic [TIME_WIDTH-1:0]      start_q;
	logic                       start_vld_q;
	logic [CNT_W-1:0]           cf_q;
	logic [frfd_pkg::IDX_W-1:0] prev_q;
	logic [CNT_W-1:0]           rc_q;

	logic [TIME_WIDTH-1:0]      ts_q;
	logic [TIME_WIDTH-1:0]      ela_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       is50_q;
	logic [DEN_W-1:0]           den_q;
	logic [DW-1:0]              t_q;
	logic [DW-1:0]              rem_q;
	logic [QUO_W-1:0]           quo_q;
	frfd_pkg::res_t             res_q;

	logic [RS_W-1:0]            n_c;
	logic                       step2;
	logic [RS_W-1:0]            a_c;
	logic [RS_W-1:0]            b_c;
	logic [RS_W:0]              dist6;
	logic [CNT_W-1:0]           cf_new;
	logic                       eligible;
	logic                       meas_point;

	frfd_pkg::alu_op_t          alu_op;
	logic [DW-1:0]              alu_a;
	logic [DW-1:0]              alu_b;
	logic [DW-1:0]              alu_sum;
	logic                       alu_borrow;
	logic [DW-1:0]              div_r;
	logic                       den_zero;

	logic [FT_W-1:0]            ft_c;
	frfd_pkg::rate_class_t      cls_c;
	logic                       want_c;
	logic [CNT_W-1:0]           rc_inc;

	// ring size clamp and field advance
	always_comb begin
		if (cfg.ring_size < RS_W'(2)) begin
			n_c = RS_W'(2);
		end else if (int'(cfg.ring_size) > RING_CAP) begin
			n_c = RS_W'(RING_CAP);
		end else begin
			n_c = cfg.ring_size;
		end
		step2 = (picture_kind == frfd_pkg::KIND_ODD);
		a_c = mod_small(step2 ? {frame_index, 1'b0} : {1'b0, frame_index}, n_c);
		b_c = mod_small(step2 ? {prev_q, 1'b0} : {1'b0, prev_q}, n_c);
		dist6 = {1'b0, a_c} + {1'b0, n_c} - {1'b0, b_c};
		if (dist6 >= {1'b0, n_c}) begin
			dist6 = dist6 - {1'b0, n_c};
		end
		cf_new = cf_q + dist6;
		eligible = cfg.enable_detect && !running_late
			&& (picture_kind == frfd_pkg::KIND_ODD || picture_kind == frfd_pkg::KIND_PROG);
		meas_point = (cf_new >= {1'b0, n_c});
	end

	// operand select for the shared adder
	assign div_r    = {rem_q[DW-2:0], t_q[QUO_W-1]};
	assign den_zero = (den_q == '0);

	always_comb begin
		alu_op.sub = 1'b0;
		alu_a      = '0;
		alu_b      = '0;
		case (state_q)
			ST_ELAP: begin
				alu_op.sub = 1'b1;
				alu_a      = DW'(ts_q);
				alu_b      = DW'(start_q);
			end
			ST_MUL: begin
				alu_a = DW'({den_q[DEN_W-2:0], 1'b0});
				alu_b = cnt_q[CNT_W-1] ? DW'(cfg.ticks_per_second) : '0;
			end
			ST_SEV: begin
				alu_op.sub = 1'b1;
				alu_a      = DW'({den_q, 3'b000});
				alu_b      = DW'(den_q);
			end
			ST_CMP: begin
				alu_op.sub = 1'b1;
				alu_a      = DW'(ela_q);
				alu_b      = t_q;
			end
			ST_NUM: begin
				alu_a = t_q;
				alu_b = DW'(ela_q) << num_shift(step_q[2:0]);
			end
			ST_RND: begin
				alu_a = t_q;
				alu_b = DW'(den_q >> 1);
			end
			ST_DIV: begin
				alu_op.sub = 1'b1;
				alu_a      = div_r;
				alu_b      = DW'(den_q);
			end
			default: begin
				alu_op.sub = 1'b0;
			end
		endcase
	end

	frfd_alu #(
		.W(DW)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.sum    (alu_sum),
		.borrow (alu_borrow)
	);

	// band classification and repeat count
	always_comb begin
		ft_c = quo_q[QUO_W-1] ? frfd_pkg::FT_SAT : quo_q[FT_W-1:0];
		if (ft_c >= frfd_pkg::BAND50_LO && ft_c <= frfd_pkg::BAND50_HI) begin
			cls_c = frfd_pkg::CLS_50HZ;
		end else if ((ft_c >= frfd_pkg::BAND60A_LO && ft_c <= frfd_pkg::BAND60A_HI)
			|| (ft_c >= frfd_pkg::BAND60B_LO && ft_c <= frfd_pkg::BAND60B_HI)) begin
			cls_c = frfd_pkg::CLS_60HZ;
		end else begin
			cls_c = frfd_pkg::CLS_UNEXP;
		end
		want_c = (cls_c == frfd_pkg::CLS_50HZ) ? !is50_q : is50_q;
		rc_inc = (&rc_q) ? rc_q : rc_q + CNT_W'(1);
	end

	// sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			start_q     <= '0;
			start_vld_q <= 1'b0;
			cf_q        <= '0;
			prev_q      <= '0;
			rc_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_FIN;
						if (eligible) begin
							prev_q <= frame_index;
							if (meas_point) begin
								cf_q <= '0;
								if (start_vld_q) begin
									step_q  <= STEP_W'(CNT_W - 1);
									state_q <= ST_ELAP;
								end else begin
									start_q     <= timestamp;
									start_vld_q <= 1'b1;
								end
							end else begin
								cf_q <= cf_new;
							end
						end
					end
				end
				ST_ELAP: begin
					start_q <= ts_q;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (step_q == '0) begin
						state_q <= ST_SEV;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_SEV: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!alu_borrow || den_zero) begin
						state_q <= ST_CLS;
					end else begin
						step_q  <= '0;
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (step_q == STEP_W'(NUM_TERMS - 1)) begin
						state_q <= ST_RND;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_RND: begin
					step_q  <= STEP_W'(QUO_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_CLS;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_CLS: begin
					if (cls_c == frfd_pkg::CLS_UNEXP) begin
						rc_q <= '0;
					end else if (want_c) begin
						rc_q <= rc_inc;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_q  <= '0;
					ts_q   <= timestamp;
					cnt_q  <= cf_new;
					is50_q <= source_is_50hz;
					den_q  <= '0;
				end
			end
			ST_ELAP: begin
				ela_q <= alu_sum[TIME_WIDTH-1:0];
			end
			ST_MUL: begin
				den_q <= alu_sum[DEN_W-1:0];
				cnt_q <= {cnt_q[CNT_W-2:0], 1'b0};
			end
			ST_SEV: begin
				t_q <= alu_sum;
			end
			ST_CMP: begin
				if (!alu_borrow || den_zero) begin
					quo_q <= '1;
				end else begin
					t_q <= '0;
				end
			end
			ST_NUM: begin
				t_q <= alu_sum;
			end
			ST_RND: begin
				t_q   <= alu_sum;
				rem_q <= alu_sum >> QUO_W;
				quo_q <= '0;
			end
			ST_DIV: begin
				if (!alu_borrow) begin
					rem_q <= alu_sum;
				end else begin
					rem_q <= div_r;
				end
				quo_q <= {quo_q[QUO_W-2:0], !alu_borrow};
				t_q   <= t_q << 1;
			end
			ST_CLS: begin
				res_q.measurement_done <= 1'b1;
				res_q.field_time_x10   <= ft_c;
				res_q.rate_class       <= cls_c;
				if (cls_c != frfd_pkg::CLS_UNEXP && want_c && rc_inc > cfg.change_threshold) begin
					res_q.switch_request <= 1'b1;
					res_q.switch_format  <= (cls_c == frfd_pkg::CLS_50HZ) ? cfg.format_50
						: cfg.format_60;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);
	assign emit = (state_q == ST_FIN) && out_free;
	assign res  = res_q;

endmodule

@@ hdl/field_rate_format_detector_top.sv @@
// an ignored or non-measuring beat goes straight to its result; a measurement uses
// the shift-add multiply (6 steps) and the restoring divide (17 steps), which share
// one adder under the sequencer; a saturated measurement skips the divide
// a new beat is taken only once the previous result has left the core
// reset: arst_n clears sequencer, field count and repeat count, loads register defaults
`timescale 1ns / 1ps

module field_rate_format_detector_top #(
	parameter int RING_MAX   = frfd_pkg::RING_MAX_DEF,
	parameter int TIME_WIDTH = frfd_pkg::TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	frfd_field_if.sink                     field,
	frfd_result_if.source                  result,
	input  logic                           wr_en,
	input  logic [frfd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [frfd_pkg::CFG_W-1:0]     wr_data
);

	frfd_pkg::cfg_t cfg_q;
	frfd_pkg::res_t core_res;
	frfd_pkg::res_t out_q;
	logic           out_vld_q;
	logic           core_idle;
	logic           core_emit;
	logic           out_free;
	logic           start;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_detect    <= 1'b1;
			cfg_q.change_threshold <= 6'd2;
			cfg_q.ticks_per_second <= 32'd27000000;
			cfg_q.ring_size        <= 5'd4;
			cfg_q.format_50        <= 8'd0;
			cfg_q.format_60        <= 8'd1;
		end else if (wr_en) begin
			case (frfd_pkg::cfg_reg_t'(wr_index))
				frfd_pkg::REG_ENABLE_DETECT:    cfg_q.enable_detect    <= wr_data[0];
				frfd_pkg::REG_CHANGE_THRESHOLD: cfg_q.change_threshold <= wr_data[5:0];
				frfd_pkg::REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= wr_data[31:0];
				frfd_pkg::REG_RING_SIZE:        cfg_q.ring_size        <= wr_data[4:0];
				frfd_pkg::REG_FORMAT_50:        cfg_q.format_50        <= wr_data[7:0];
				frfd_pkg::REG_FORMAT_60:        cfg_q.format_60        <= wr_data[7:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// input handshake
	assign start       = field.valid && core_idle;
	assign field.ready = core_idle;

	frfd_core #(
		.RING_MAX   (RING_MAX),
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.start          (start),
		.timestamp      (field.timestamp),
		.running_late   (field.running_late),
		.picture_kind   (field.picture_kind),
		.frame_index    (field.frame_index),
		.source_is_50hz (field.source_is_50hz),
		.idle           (core_idle),
		.emit           (core_emit),
		.out_free       (out_free),
		.res            (core_res)
	);

	// output register
	assign out_free = !out_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (core_emit) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_emit) begin
			out_q <= core_res;
		end
	end

	assign result.valid            = out_vld_q;
	assign result.measurement_done = out_q.measurement_done;
	assign result.field_time_x10   = out_q.field_time_x10;
	assign result.rate_class       = out_q.rate_class;
	assign result.switch_request   = out_q.switch_request;
	assign result.switch_format    = out_q.switch_format;

endmodule

@@ hdl/frfd_checker.sv @@
`timescale 1ns / 1ps
`include "field_rate_format_detector_top_macros.svh"

module frfd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       done,
	input logic [frfd_pkg::FT_W-1:0]  ftime,
	input logic [1:0]                 cls,
	input logic                       req,
	input logic [frfd_pkg::FMT_W-1:0] fmt
);

	// block is busy right after taking a beat
	`FRFD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready high right after accept")

	// a switch only follows a measurement in a known band
	`FRFD_ASSERT_IMPLY(a_req_has_band, clk, arst_n, out_valid && req, done && (cls == frfd_pkg::CLS_50HZ || cls == frfd_pkg::CLS_60HZ), "switch without band")

	// no measurement means an empty result
	`FRFD_ASSERT_IMPLY(a_empty_result, clk, arst_n, out_valid && !done, ftime == '0 && cls == frfd_pkg::CLS_NONE && !req && fmt == '0, "stray result fields")

	// stalled result holds
	`FRFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({done, ftime, cls, req, fmt}), "stalled result changed")

endmodule

bind field_rate_format_detector_top frfd_checker u_frfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (field.valid),
	.in_ready  (field.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.done      (result.measurement_done),
	.ftime     (result.field_time_x10),
	.cls       (result.rate_class),
	.req       (result.switch_request),
	.fmt       (result.switch_format)
);

@@ dv/field_rate_format_detector_top_tb.sv @@
`timescale 1ns / 1ps

module field_rate_format_detector_top_tb;

	localparam int          IDX_W         = frfd_pkg::IDX_W;
	localparam int          CNT_W         = frfd_pkg::CNT_W;
	localparam int          THR_W         = frfd_pkg::THR_W;
	localparam int          TPS_W         = frfd_pkg::TPS_W;
	localparam int          RS_W          = frfd_pkg::RS_W;
	localparam int          FMT_W         = frfd_pkg::FMT_W;
	localparam int          FT_W          = frfd_pkg::FT_W;
	localparam int          CFG_IDX_W     = frfd_pkg::CFG_IDX_W;
	localparam int          CFG_W         = frfd_pkg::CFG_W;
	localparam int          RING_MAX_DEF  = frfd_pkg::RING_MAX_DEF;
	localparam logic [1:0]  KIND_RESERVED = 2'd3;
	localparam int          RUN_LIMIT     = 1000000;
	localparam int          RANDOM_BEATS  = 800;
	localparam int          REPORT_LIMIT  = 10;
	localparam logic [31:0] DIR_START     = 32'hFFE0_0000;
	localparam logic [31:0] DIR_PERIOD    = 32'd540000;

	typedef struct packed {
		logic [31:0]      ts;
		logic             late;
		logic [1:0]       kind;
		logic [IDX_W-1:0] idx;
		logic             is50;
	} field_beat_t;

	// tracks the detector state and holds the results still owed by the block
	class rate_checker;
		frfd_pkg::cfg_t   cfg;
		logic [CNT_W-1:0] repeats;
		logic [31:0]      start_stamp;
		logic             start_ok;
		logic [CNT_W-1:0] fields_seen;
		logic [IDX_W-1:0] last_index;
		frfd_pkg::res_t   pending_rates[$];
		int               errors;
		int               noted_beats;

		function new();
			cfg.enable_detect    = 1'b1;
			cfg.change_threshold = 6'd2;
			cfg.ticks_per_second = 32'd27000000;
			cfg.ring_size        = 5'd4;
			cfg.format_50        = 8'd0;
			cfg.format_60        = 8'd1;
			repeats     = '0;
			start_stamp = '0;
			start_ok    = 1'b0;
			fields_seen = '0;
			last_index  = '0;
			errors      = 0;
			noted_beats = 0;
		endfunction

		function void set_reg(frfd_pkg::cfg_reg_t r, logic [31:0] v);
			case (r)
				frfd_pkg::REG_ENABLE_DETECT:    cfg.enable_detect    = v[0];
				frfd_pkg::REG_CHANGE_THRESHOLD: cfg.change_threshold = v[THR_W-1:0];
				frfd_pkg::REG_TICKS_PER_SECOND: cfg.ticks_per_second = v[TPS_W-1:0];
				frfd_pkg::REG_RING_SIZE:        cfg.ring_size        = v[RS_W-1:0];
				frfd_pkg::REG_FORMAT_50:        cfg.format_50        = v[FMT_W-1:0];
				frfd_pkg::REG_FORMAT_60:        cfg.format_60        = v[FMT_W-1:0];
				default: ;
			endcase
		endfunction

		function frfd_pkg::res_t predict_rate_result(field_beat_t b);
			frfd_pkg::res_t  r;
			int unsigned     n, mult, cur_pos, old_pos;
			logic [31:0]     elapsed;
			longint unsigned den, q;
			logic            want;
			r = '0;
			n = cfg.ring_size;
			if (n < 2) n = 2;
			if (n > RING_MAX_DEF) n = RING_MAX_DEF;
			if (!cfg.enable_detect || b.late
					|| !(b.kind == frfd_pkg::KIND_ODD || b.kind == frfd_pkg::KIND_PROG))
				return r;

			// ring distance since the last counted beat, doubled for odd fields
			mult = (b.kind == frfd_pkg::KIND_ODD) ? 2 : 1;
			cur_pos = (b.idx * mult) % n;
			old_pos = (last_index * mult) % n;
			fields_seen = fields_seen + CNT_W'((cur_pos + n - old_pos) % n);
			last_index = b.idx;
			if (fields_seen < n)
				return r;

			if (start_ok) begin
				// ten-field time in ms, rounded, saturated
				elapsed = b.ts - start_stamp;
				den = 64'(cfg.ticks_per_second) * 64'(fields_seen);
				if (den == 0 || 64'(elapsed) >= 7 * den) begin
					r.field_time_x10 = frfd_pkg::FT_SAT;
				end else begin
					q = (64'(elapsed) * 10000 + den / 2) / den;
					r.field_time_x10 = (q > 65535) ? frfd_pkg::FT_SAT : q[FT_W-1:0];
				end
				r.measurement_done = 1'b1;

				// band classification
				if (r.field_time_x10 >= frfd_pkg::BAND50_LO
						&& r.field_time_x10 <= frfd_pkg::BAND50_HI)
					r.rate_class = frfd_pkg::CLS_50HZ;
				else if ((r.field_time_x10 >= frfd_pkg::BAND60A_LO
						&& r.field_time_x10 <= frfd_pkg::BAND60A_HI) ||
						(r.field_time_x10 >= frfd_pkg::BAND60B_LO
						&& r.field_time_x10 <= frfd_pkg::BAND60B_HI))
					r.rate_class = frfd_pkg::CLS_60HZ;
				else
					r.rate_class = frfd_pkg::CLS_UNEXP;

				// repeat count and switch request
				if (r.rate_class == frfd_pkg::CLS_UNEXP) begin
					repeats = '0;
				end else begin
					want = (r.rate_class == frfd_pkg::CLS_50HZ) ? !b.is50 : b.is50;
					if (want) begin
						if (repeats != 6'd63) repeats++;
						if (repeats > cfg.change_threshold) begin
							r.switch_request = 1'b1;
							r.switch_format = (r.rate_class == frfd_pkg::CLS_50HZ) ?
								cfg.format_50 : cfg.format_60;
						end
					end
				end
			end
			start_stamp = b.ts;
			start_ok    = 1'b1;
			fields_seen = '0;
			return r;
		endfunction

		function void note_field(field_beat_t b);
			noted_beats++;
			pending_rates.push_back(predict_rate_result(b));
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
		endfunction

		function void compare_field(string name, logic [15:0] w, logic [15:0] g);
			if (g !== w) report($sformatf("%s mismatch: expected %0d, actual %0d", name, w, g));
		endfunction

		function void check_rate(frfd_pkg::res_t got);
			frfd_pkg::res_t w;
			if (pending_rates.size() == 0) begin
				report($sformatf("result beat with nothing pending: %p", got));
				return;
			end
			w = pending_rates.pop_front();
			compare_field("measurement_done", 16'(w.measurement_done), 16'(got.measurement_done));
			compare_field("field_time_x10", w.field_time_x10, got.field_time_x10);
			compare_field("rate_class", 16'(w.rate_class), 16'(got.rate_class));
			compare_field("switch_request", 16'(w.switch_request), 16'(got.switch_request));
			compare_field("switch_format", 16'(w.switch_format), 16'(got.switch_format));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 tx_steady = 1'b0;
	logic                 rx_steady = 1'b0;
	int                   rx_hold = 0;
	int unsigned          cycles = 0;
	rate_checker          sb;

	frfd_field_if  field_ch ();
	frfd_result_if result_ch ();

	field_rate_format_detector_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.field    (field_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(5, 60);
	endfunction

	function automatic field_beat_t make_beat(logic [31:0] ts, logic late, logic [1:0] kind,
			logic [IDX_W-1:0] idx, logic is50);
		field_beat_t b;
		b.ts   = ts;
		b.late = late;
		b.kind = kind;
		b.idx  = idx;
		b.is50 = is50;
		return b;
	endfunction

	// result side backpressure
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			if (!rx_steady && $urandom_range(0, 99) < 20) rx_hold = pick_gap();
		end
	end

	// beat monitors
	always @(posedge clk) begin
		field_beat_t    seen;
		frfd_pkg::res_t got;
		if (arst_n && field_ch.valid && field_ch.ready) begin
			seen.ts   = field_ch.timestamp;
			seen.late = field_ch.running_late;
			seen.kind = field_ch.picture_kind;
			seen.idx  = field_ch.frame_index;
			seen.is50 = field_ch.source_is_50hz;
			sb.note_field(seen);
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.measurement_done = result_ch.measurement_done;
			got.field_time_x10   = result_ch.field_time_x10;
			got.rate_class       = result_ch.rate_class;
			got.switch_request   = result_ch.switch_request;
			got.switch_format    = result_ch.switch_format;
			sb.check_rate(got);
		end
	end

	// one field beat, returns at the accepting edge with valid still high
	task automatic put_field(field_beat_t b);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			field_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		field_ch.valid          <= 1'b1;
		field_ch.timestamp      <= b.ts;
		field_ch.running_late   <= b.late;
		field_ch.picture_kind   <= b.kind;
		field_ch.frame_index    <= b.idx;
		field_ch.source_is_50hz <= b.is50;
		do @(posedge clk); while (field_ch.ready !== 1'b1);
	endtask

	// wait for every owed result, then let the block go quiet
	task automatic settle();
		field_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_rates.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(frfd_pkg::cfg_reg_t r, logic [31:0] v);
		wr_en    <= 1'b1;
		wr_index <= r;
		wr_data  <= v;
		@(posedge clk);
		sb.set_reg(r, v);
	endtask

	task automatic load_config(frfd_pkg::cfg_t c);
		write_reg(frfd_pkg::REG_ENABLE_DETECT, 32'(c.enable_detect));
		write_reg(frfd_pkg::REG_CHANGE_THRESHOLD, 32'(c.change_threshold));
		write_reg(frfd_pkg::REG_TICKS_PER_SECOND, c.ticks_per_second);
		write_reg(frfd_pkg::REG_RING_SIZE, 32'(c.ring_size));
		write_reg(frfd_pkg::REG_FORMAT_50, 32'(c.format_50));
		write_reg(frfd_pkg::REG_FORMAT_60, 32'(c.format_60));
		wr_en <= 1'b0;
	endtask

	function automatic frfd_pkg::cfg_t pick_config(int phase);
		frfd_pkg::cfg_t c;
		c.enable_detect = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 4))
			0: c.change_threshold = 6'd0;
			1: c.change_threshold = 6'd1;
			2: c.change_threshold = 6'd2;
			3: c.change_threshold = THR_W'($urandom_range(3, 8));
			default: c.change_threshold = THR_W'($urandom_range(0, 63));
		endcase
		case ($urandom_range(0, 5))
			0: c.ticks_per_second = 32'd27000000;
			1: c.ticks_per_second = 32'd90000;
			2: c.ticks_per_second = 32'd1000;
			3: c.ticks_per_second = 32'hFFFF_FFFF;
			4: c.ticks_per_second = $urandom;
			default: c.ticks_per_second = $urandom_range(1, 100);
		endcase
		case ($urandom_range(0, 4))
			0: c.ring_size = 5'd2;
			1: c.ring_size = 5'd4;
			2: c.ring_size = 5'd16;
			3: c.ring_size = RS_W'($urandom_range(2, 16));
			default: c.ring_size = RS_W'($urandom_range(0, 31));
		endcase
		c.format_50 = FMT_W'($urandom);
		c.format_60 = FMT_W'($urandom);
		// first phases pin the register extremes
		case (phase)
			0: begin
				c.enable_detect    = 1'b1;
				c.ring_size        = 5'd0;
				c.change_threshold = 6'd0;
				c.ticks_per_second = 32'd1000;
				c.format_50        = 8'd0;
				c.format_60        = 8'd255;
			end
			1: begin
				c.enable_detect    = 1'b1;
				c.ring_size        = 5'd31;
				c.change_threshold = 6'd63;
				c.ticks_per_second = 32'hFFFF_FFFF;
				c.format_50        = 8'd255;
				c.format_60        = 8'd0;
			end
			2: c.enable_detect = 1'b0;
			3: begin
				c.enable_detect    = 1'b1;
				c.ring_size        = 5'd1;
				c.ticks_per_second = 32'd1;
				c.change_threshold = 6'd1;
			end
			default: ;
		endcase
		return c;
	endfunction

	// a run of fields at one rate, or a burst of noise
	task automatic send_stretch(int beats);
		int unsigned      n, rate, k, stride;
		logic [31:0]      t, period, jit, stamp;
		logic [IDX_W-1:0] idx;
		logic             is50, woven, late;
		n = sb.cfg.ring_size;
		if (n < 2) n = 2;
		if (n > RING_MAX_DEF) n = RING_MAX_DEF;

		// noise
		if ($urandom_range(0, 9) == 0) begin
			repeat (beats)
				put_field(make_beat($urandom, 1'($urandom_range(0, 1)),
					2'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
			return;
		end

		// 50 Hz, 60 Hz, 30 Hz, or an arbitrary period
		rate = $urandom_range(0, 3);
		case (rate)
			0: period = sb.cfg.ticks_per_second / 50;
			1: period = sb.cfg.ticks_per_second / 60;
			2: period = sb.cfg.ticks_per_second / 30;
			default: period = $urandom >> $urandom_range(0, 31);
		endcase
		// mostly the other format, so that switches get requested
		is50 = (rate == 0) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 3) != 0);
		woven = 1'($urandom_range(0, 1));
		jit = period >> 8;
		t = $urandom;
		k = $urandom_range(0, n - 1);

		repeat (beats) begin
			late = ($urandom_range(0, 99) < 4);
			if ($urandom_range(0, 99) < 3)
				put_field(make_beat($urandom, 1'b0, KIND_RESERVED,
					IDX_W'($urandom_range(0, 15)), is50));
			// index aliased past the ring now and then
			idx = IDX_W'(k);
			if (k + n < 16 && $urandom_range(0, 19) == 0) idx = IDX_W'(k + n);
			stamp = t + $urandom_range(0, jit);
			if (woven) begin
				put_field(make_beat(stamp, late, frfd_pkg::KIND_ODD, idx, is50));
				put_field(make_beat(stamp + period, $urandom_range(0, 99) < 4,
					frfd_pkg::KIND_EVEN, idx, is50));
				t += 2 * period;
			end else begin
				put_field(make_beat(stamp, late, frfd_pkg::KIND_PROG, idx, is50));
				t += period;
			end
			// dropped frame
			stride = ($urandom_range(0, 24) == 0) ? 2 : 1;
			if (stride == 2) t += woven ? 2 * period : period;
			k = (k + stride) % n;
		end
	endtask

	initial begin
		frfd_pkg::cfg_t c;
		int             goal, phase, sent, len;
		logic [3:0]     idx;
		sb = new();
		field_ch.valid          = 1'b0;
		field_ch.timestamp      = '0;
		field_ch.running_late   = 1'b0;
		field_ch.picture_kind   = frfd_pkg::KIND_ODD;
		field_ch.frame_index    = '0;
		field_ch.source_is_50hz = 1'b0;
		result_ch.ready         = 1'b0;
		wr_en    = 1'b0;
		wr_index = frfd_pkg::REG_ENABLE_DETECT;
		wr_data  = '0;
		arst_n   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored beats at the field extremes
		put_field(make_beat(32'hFFFF_FFFF, 1'b1, frfd_pkg::KIND_PROG, 4'd15, 1'b1));
		put_field(make_beat(32'h0, 1'b0, frfd_pkg::KIND_EVEN, 4'd0, 1'b0));
		put_field(make_beat(32'hFFFF_FFFF, 1'b0, KIND_RESERVED, 4'd15, 1'b1));

		// progressive 50 Hz across the timestamp wrap: first point, then three
		// measurements that build up to a switch request; aliased indexes first
		for (int r = 0; r < 4; r++)
			for (int j = 1; j <= 4; j++) begin
				idx = 4'(j % 4);
				if (r == 0 && j < 3) idx = idx + 4'd12;
				put_field(make_beat(DIR_START + (4 * r + j - 1) * DIR_PERIOD, 1'b0,
					frfd_pkg::KIND_PROG, idx, 1'b0));
			end

		// odd fields measuring 50 Hz while already in 50 Hz
		put_field(make_beat(DIR_START + 17 * DIR_PERIOD, 1'b0, frfd_pkg::KIND_ODD, 4'd1, 1'b1));
		put_field(make_beat(DIR_START + 19 * DIR_PERIOD, 1'b0, frfd_pkg::KIND_ODD, 4'd2, 1'b1));
		settle();

		// zero tick rate saturates and clears the repeat count
		c.enable_detect    = 1'b1;
		c.change_threshold = 6'd0;
		c.ticks_per_second = 32'd0;
		c.ring_size        = 5'd4;
		c.format_50        = 8'd255;
		c.format_60        = 8'd0;
		load_config(c);
		for (int j = 3; j <= 6; j++)
			put_field(make_beat($urandom, 1'b0, frfd_pkg::KIND_PROG, 4'(j % 4), 1'b0));
		settle();

		// random phases, each under its own register setting
		goal = sb.noted_beats + RANDOM_BEATS;
		phase = 0;
		while (sb.noted_beats < goal && phase < 60) begin
			load_config(pick_config(phase));
			tx_steady <= ($urandom_range(0, 3) == 0);
			rx_steady <= ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < 120) begin
				len = $urandom_range(6, 40);
				send_stretch(len);
				sent += len;
			end
			settle();
			phase++;
		end

		if (sb.errors == 0 && sb.pending_rates.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
